FILE: rtl/core/srp_pkg.sv
// Shared types, constants and helper functions of the shelf rectangle packer.
`timescale 1ns / 1ps

package srp_pkg;

    localparam int SIDE_W  = 15;
    localparam int INDEX_W = 16;
    localparam int POW2_W  = 16;

    localparam logic [SIDE_W-1:0] C_MAX_SIDE   = 15'd16384;
    localparam logic [SIDE_W-1:0] C_ATLAS_RST  = 15'd2048;
    localparam logic [SIDE_W-1:0] C_SAT_SIDE   = 15'h7FFF;

    typedef enum logic {
        KIND_CLOSE = 1'b0,
        KIND_PLACE = 1'b1
    } t_kind;

    typedef struct packed {
        logic              fin;
        logic [SIDE_W-1:0] h;
        logic [SIDE_W-1:0] w;
    } t_rect;

    typedef struct packed {
        t_kind              kind;
        logic [INDEX_W-1:0] atlas;
        logic [SIDE_W-1:0]  x;
        logic [SIDE_W-1:0]  y;
        logic [POW2_W-1:0]  wp2;
        logic [POW2_W-1:0]  hp2;
        logic               single;
        logic               run_end;
    } t_record;

    // Smallest power of two not below v; zero and one both give one.
    function automatic logic [POW2_W-1:0] round_pow2(input logic [SIDE_W-1:0] v);
        logic [POW2_W-1:0] m;
        m = {1'b0, v} - 16'd1;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        if (v == '0) begin
            return 16'd1;
        end
        return m + 16'd1;
    endfunction

    // Clamp a 16-bit sum back to the 15-bit range.
    function automatic logic [SIDE_W-1:0] sat15(input logic [SIDE_W:0] v);
        return v[SIDE_W] ? C_SAT_SIDE : v[SIDE_W-1:0];
    endfunction

endpackage

FILE: rtl/core/srp_in_reg.sv
// Input register: clamps the rectangle sides and holds the item for the placer.
`timescale 1ns / 1ps

module srp_in_reg
    import srp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [SIDE_W-1:0] i_w,
    input  logic [SIDE_W-1:0] i_h,
    input  logic              i_fin,
    input  logic              i_consume,
    output logic              o_valid,
    output t_rect             o_rect
);

    logic  r_valid;
    t_rect r_rect;
    t_rect n_rect;

    assign o_ready = !r_valid || i_consume;
    assign o_valid = r_valid;
    assign o_rect  = r_rect;

    always_comb begin
        n_rect.w   = (i_w > C_MAX_SIDE) ? C_MAX_SIDE : i_w;
        n_rect.h   = (i_h > C_MAX_SIDE) ? C_MAX_SIDE : i_h;
        n_rect.fin = i_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rect <= n_rect;
        end
    end

endmodule

FILE: rtl/core/srp_place.sv
// Shelf placer: atlas state, placement arithmetic and close record generation.
`timescale 1ns / 1ps

module srp_place
    import srp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIDE_W-1:0] i_cfg_wdata,
    input  logic              i_valid,
    input  t_rect             i_rect,
    input  logic              i_space,
    output logic              o_consume,
    output logic              o_fire,
    output t_record           o_record
);

    logic [SIDE_W-1:0]  r_size;
    logic [SIDE_W-1:0]  r_cx, r_cy, r_sh, r_uw, r_uh;
    logic [INDEX_W-1:0] r_index;
    logic [1:0]         r_rc;
    logic               r_post;

    logic [SIDE_W-1:0]  n_cx, n_cy, n_sh, n_uw, n_uh;
    logic [INDEX_W-1:0] n_index;
    logic [1:0]         n_rc;
    logic               n_post;

    logic [SIDE_W-1:0]  size_eff;
    logic [SIDE_W:0]    sum_x, sum_y, sum_h, end_x, end_y;
    logic               wrap, ovf, pre_close;
    logic [SIDE_W-1:0]  cx1, cy1, sh1, px, py, sh_base, sh_new;
    logic [SIDE_W-1:0]  cx_new, ey_sat, uw_new, uh_new;
    logic [1:0]         rc_new;
    t_record            close_rec, place_rec;

    // Placement arithmetic for the item against the current shelf.
    always_comb begin
        size_eff = (r_size == '0) ? 15'd1 : ((r_size > C_MAX_SIDE) ? C_MAX_SIDE : r_size);
        sum_x    = {1'b0, r_cx} + {1'b0, i_rect.w};
        wrap     = sum_x > {1'b0, size_eff};
        sum_y    = {1'b0, r_cy} + {1'b0, r_sh};
        cx1      = wrap ? '0 : r_cx;
        cy1      = wrap ? sat15(sum_y) : r_cy;
        sh1      = wrap ? '0 : r_sh;
        sum_h    = {1'b0, cy1} + {1'b0, i_rect.h};
        ovf      = sum_h > {1'b0, size_eff};
        pre_close = ovf && (r_rc != 2'd0);
        px       = ovf ? '0 : cx1;
        py       = ovf ? '0 : cy1;
        sh_base  = ovf ? '0 : sh1;
        sh_new   = (i_rect.h > sh_base) ? i_rect.h : sh_base;
        end_x    = {1'b0, px} + {1'b0, i_rect.w};
        end_y    = {1'b0, py} + {1'b0, i_rect.h};
        cx_new   = sat15(end_x);
        ey_sat   = sat15(end_y);
        uw_new   = (cx_new > r_uw) ? cx_new : r_uw;
        uh_new   = (ey_sat > r_uh) ? ey_sat : r_uh;
        rc_new   = (r_rc == 2'd2) ? 2'd2 : r_rc + 2'd1;
    end

    always_comb begin
        close_rec         = '0;
        close_rec.kind    = KIND_CLOSE;
        close_rec.atlas   = r_index;
        close_rec.wp2     = round_pow2(r_uw);
        close_rec.hp2     = round_pow2(r_uh);
        close_rec.single  = (r_rc == 2'd1);
        close_rec.run_end = r_post;

        place_rec         = '0;
        place_rec.kind    = KIND_PLACE;
        place_rec.atlas   = r_index;
        place_rec.x       = px;
        place_rec.y       = py;
        place_rec.run_end = !i_rect.fin;
    end

    assign o_fire = i_valid && i_space;

    always_comb begin
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_sh      = r_sh;
        n_uw      = r_uw;
        n_uh      = r_uh;
        n_index   = r_index;
        n_rc      = r_rc;
        n_post    = r_post;
        o_consume = 1'b0;
        o_record  = place_rec;
        if (r_post || pre_close) begin
            o_record = close_rec;
            if (o_fire) begin
                n_cx      = '0;
                n_cy      = '0;
                n_sh      = '0;
                n_uw      = '0;
                n_uh      = '0;
                n_rc      = 2'd0;
                n_index   = r_index + 16'd1;
                n_post    = 1'b0;
                o_consume = r_post;
            end
        end else if (o_fire) begin
            n_cx      = cx_new;
            n_cy      = py;
            n_sh      = sh_new;
            n_uw      = uw_new;
            n_uh      = uh_new;
            n_rc      = rc_new;
            n_post    = i_rect.fin;
            o_consume = !i_rect.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= C_ATLAS_RST;
            r_cx    <= '0;
            r_cy    <= '0;
            r_sh    <= '0;
            r_uw    <= '0;
            r_uh    <= '0;
            r_index <= '0;
            r_rc    <= 2'd0;
            r_post  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_sh    <= n_sh;
            r_uw    <= n_uw;
            r_uh    <= n_uh;
            r_index <= n_index;
            r_rc    <= n_rc;
            r_post  <= n_post;
        end
    end

endmodule

FILE: rtl/core/srp_out_reg.sv
// Output register: holds one result item until the downstream side takes it.
`timescale 1ns / 1ps

module srp_out_reg
    import srp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_record i_record,
    input  logic    i_ready,
    output logic    o_space,
    output logic    o_valid,
    output t_record o_record
);

    logic    r_valid;
    t_record r_record;

    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_record = r_record;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_record <= i_record;
        end
    end

endmodule

FILE: rtl/core/shelf_rectangle_packer.sv
// Top level of the shelf next-fit rectangle packer.
//
// Each input item is one rectangle; it is placed at the cursor of the current
// shelf of the open square atlas, a new shelf being started when it would pass
// the right edge and a new atlas when it would pass the bottom edge. Every
// rectangle gives a placement record; a closing atlas gives a close record
// with its used extent rounded up to powers of two and a single-image flag,
// and an atlas that never received a rectangle is never closed or numbered.
// A rectangle item normally gives one record, so a placement can be accepted on
// every clock while the output register has space; each close record it causes
// (overflow into a new atlas, or the final rectangle of a list) holds the item
// for one more record, because the placer hands exactly one record per cycle to
// the single output register while it has space. An accepted item waits in
// the input register, and its first record is loaded into the output register
// when the placer fires. The atlas side register resets to 2048 and should
// only be written while no item is in flight; zero acts as one and values
// above 16384 act as 16384. Sides above 16384 saturate to 16384 on entry.
`timescale 1ns / 1ps

module shelf_rectangle_packer
    import srp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [14:0] i_cfg_wdata,   // atlas_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // rect_width[14:0], rect_height[29:15], zero pad
    input  logic        s_tlast,       // final_rect
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,       // atlas_number[15:0], place_x[30:16],
                                       // place_y[45:31], atlas_width_pow2[61:46],
                                       // atlas_height_pow2[77:62], single_image[78],
                                       // zero pad
    output logic [0:0]  m_tuser,       // record_kind
    output logic        m_tlast        // run_end
);

    logic    w_in_valid;
    t_rect   w_rect;
    logic    w_consume;
    logic    w_fire;
    logic    w_space;
    t_record w_record;
    t_record w_out;

    srp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_tvalid),
        .o_ready   (s_tready),
        .i_w       (s_tdata[14:0]),
        .i_h       (s_tdata[29:15]),
        .i_fin     (s_tlast),
        .i_consume (w_consume),
        .o_valid   (w_in_valid),
        .o_rect    (w_rect)
    );

    srp_place u_place (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (w_in_valid),
        .i_rect      (w_rect),
        .i_space     (w_space),
        .o_consume   (w_consume),
        .o_fire      (w_fire),
        .o_record    (w_record)
    );

    srp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire),
        .i_record (w_record),
        .i_ready  (m_tready),
        .o_space  (w_space),
        .o_valid  (m_tvalid),
        .o_record (w_out)
    );

    assign m_tdata = {1'b0, w_out.single, w_out.hp2, w_out.wp2,
                      w_out.y, w_out.x, w_out.atlas};
    assign m_tuser = w_out.kind;
    assign m_tlast = w_out.run_end;

    // A close record always reports power-of-two extents.
    a_close_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == KIND_CLOSE) |-> ($onehot(w_out.wp2) && $onehot(w_out.hp2)))
        else $error("close record with an extent that is not a power of two");

    // Only close records may carry the single-image flag or extents.
    a_place_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == KIND_PLACE) |->
            (!w_out.single && w_out.wp2 == '0 && w_out.hp2 == '0))
        else $error("placement record carries close fields");

    // The input item is released only when a record is actually issued.
    a_consume_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_consume |-> (w_fire && w_in_valid))
        else $error("input item released without issuing a record");

endmodule

FILE: tb/sv/tb_shelf_rectangle_packer.sv
// Self-checking testbench for the shelf rectangle packer, with a built-in placement predictor.
`timescale 1ns / 1ps

module tb_shelf_rectangle_packer;
    import srp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [14:0] i_cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    shelf_rectangle_packer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // Predictor state: a private copy of the packer's atlas bookkeeping.
    logic [14:0]  atlas_side_reg = C_ATLAS_RST;
    int unsigned  cur_x = 0, cur_y = 0, shelf_h = 0, used_w = 0, used_h = 0;
    logic [15:0]  atlas_idx = '0;
    int unsigned  rect_count = 0;

    t_record      pending_records[$];
    int unsigned  mismatches = 0;
    bit           idle_on = 1'b1;
    int unsigned  hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Generous limit: far beyond the slowest correct run with every stall at its longest.
    initial begin
        #5_000_000;
        $display("tb_shelf_rectangle_packer: errors");
        $finish;
    end

    function automatic int unsigned clamp_side(input int unsigned v);
        return (v > C_MAX_SIDE) ? C_MAX_SIDE : v;
    endfunction

    function automatic int unsigned clip15(input int unsigned v);
        return (v > C_SAT_SIDE) ? C_SAT_SIDE : v;
    endfunction

    function automatic int unsigned next_pow2(input int unsigned v);
        int unsigned p;
        p = 1;
        while (p < v && p < 32768) p = p << 1;
        return p;
    endfunction

    // Closes the open atlas: queues its close record and starts an empty one.
    function automatic void close_atlas(input logic last);
        t_record rec;
        rec         = '0;
        rec.kind    = KIND_CLOSE;
        rec.atlas   = atlas_idx;
        rec.wp2     = 16'(next_pow2(used_w));
        rec.hp2     = 16'(next_pow2(used_h));
        rec.single  = (rect_count == 1);
        rec.run_end = last;
        pending_records = {pending_records, rec};
        atlas_idx  = atlas_idx + 16'd1;
        cur_x      = 0;
        cur_y      = 0;
        shelf_h    = 0;
        used_w     = 0;
        used_h     = 0;
        rect_count = 0;
    endfunction

    // Works out the records that one accepted rectangle causes.
    function automatic void place_rect(input logic [14:0] w_in, input logic [14:0] h_in,
                                       input logic fin);
        int unsigned w, h, side, px, py;
        t_record     rec;
        w    = clamp_side(32'(w_in));
        h    = clamp_side(32'(h_in));
        side = (atlas_side_reg == '0) ? 1 : clamp_side(32'(atlas_side_reg));
        // Past the right edge: start a new shelf below the tallest rectangle of the current shelf.
        if (cur_x + w > side) begin
            cur_x   = 0;
            cur_y   = clip15(cur_y + shelf_h);
            shelf_h = 0;
        end
        // Past the bottom edge: close the atlas, unless it is still empty.
        if (cur_y + h > side) begin
            if (rect_count != 0) begin
                close_atlas(1'b0);
            end else begin
                cur_x   = 0;
                cur_y   = 0;
                shelf_h = 0;
            end
        end
        if (h > shelf_h) shelf_h = h;
        px          = cur_x;
        py          = cur_y;
        rec         = '0;
        rec.kind    = KIND_PLACE;
        rec.atlas   = atlas_idx;
        rec.x       = 15'(px);
        rec.y       = 15'(py);
        rec.run_end = !fin;
        pending_records = {pending_records, rec};
        cur_x = clip15(px + w);
        if (cur_x > used_w) used_w = cur_x;
        if (clip15(py + h) > used_h) used_h = clip15(py + h);
        if (rect_count < 2) rect_count++;
        if (fin) close_atlas(1'b1);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Compares every accepted record with the oldest one still awaited.
    always @(posedge i_clk) begin
        t_record want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_records.size() == 0) begin
                $error("record arrived with none awaited: tdata %h", m_tdata);
                mismatches++;
            end else begin
                want = pending_records.pop_front();
                check_field("record_kind", 32'(want.kind), 32'(m_tuser[0]));
                check_field("atlas_number", 32'(want.atlas), 32'(m_tdata[15:0]));
                check_field("place_x", 32'(want.x), 32'(m_tdata[30:16]));
                check_field("place_y", 32'(want.y), 32'(m_tdata[45:31]));
                check_field("atlas_width_pow2", 32'(want.wp2), 32'(m_tdata[61:46]));
                check_field("atlas_height_pow2", 32'(want.hp2), 32'(m_tdata[77:62]));
                check_field("single_image", 32'(want.single), 32'(m_tdata[78]));
                check_field("run_end", 32'(want.run_end), 32'(m_tlast));
            end
        end
    end

    // Receiver: a long hold when asked for, otherwise random stall bursts.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                m_tready <= 1'b0;
            end else if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready   <= 1'b0;
                stall_left = $urandom_range(1, 13) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offers one rectangle, sometimes after an idle burst, and waits for it to be taken.
    task automatic send_rect(input logic [14:0] w, input logic [14:0] h, input logic fin);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, h, w};
        s_tlast  <= fin;
        do @(posedge i_clk); while (!s_tready);
        place_rect(w, h, fin);
    endtask

    // Stops offering and waits until every awaited record has come out.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_atlas_size(input logic [14:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        atlas_side_reg = v;
    endtask

    // Zero and full sides, oversized inputs, row and atlas overflow, final rectangles,
    // a rectangle larger than the atlas landing in an empty one, and single-image atlases.
    task automatic test_directed_shapes;
        send_rect(15'd0, 15'd0, 1'b0);
        send_rect(15'd16384, 15'd16384, 1'b0);
        send_rect(15'h7FFF, 15'h7FFF, 1'b1);
        send_rect(15'd16384, 15'd100, 1'b0);
        send_rect(15'd1, 15'd1, 1'b0);
        send_rect(15'd2047, 15'd1, 1'b0);
        send_rect(15'd1000, 15'd2000, 1'b0);
        send_rect(15'h3FFF, 15'h3FFF, 1'b0);
        send_rect(15'd100, 15'd100, 1'b1);
        send_rect(15'd5, 15'd5, 1'b1);
        send_rect(15'h4000, 15'h2AAA, 1'b0);
        send_rect(15'h1555, 15'h0000, 1'b1);
    endtask

    // Atlas side at its extremes, including zero and values beyond the largest side.
    task automatic test_atlas_extremes;
        write_atlas_size(15'd0);
        send_rect(15'd1, 15'd1, 1'b0);
        send_rect(15'd1, 15'd1, 1'b0);
        send_rect(15'd0, 15'd0, 1'b1);
        write_atlas_size(15'd1);
        send_rect(15'd2, 15'd2, 1'b0);
        send_rect(15'd1, 15'd0, 1'b1);
        write_atlas_size(15'h7FFF);
        send_rect(15'd16384, 15'd8192, 1'b0);
        send_rect(15'd1, 15'd8192, 1'b0);
        send_rect(15'd16384, 15'd1, 1'b1);
        write_atlas_size(15'd16384);
        send_rect(15'd8192, 15'd16384, 1'b0);
        send_rect(15'd8193, 15'd1, 1'b1);
        write_atlas_size(15'd16385);
        send_rect(15'd16384, 15'd16384, 1'b1);
    endtask

    // Random lists, each ending in a final rectangle; about one item in eight is noise
    // drawn from the whole field range.
    task automatic run_lists(input int n_items, input int unsigned side_hint);
        int sent, len, k;
        int unsigned span;
        logic [14:0] w, h;
        span = (side_hint < 4) ? 1 : side_hint / 3;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 8);
            for (k = 0; k < len && sent < n_items; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    w = 15'($urandom_range(0, 32767));
                    h = 15'($urandom_range(0, 32767));
                end else begin
                    w = 15'($urandom_range(0, span));
                    h = 15'($urandom_range(0, span));
                end
                send_rect(w, h, (k == len - 1) || (sent == n_items - 1));
                sent++;
            end
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering,
    // so the packer fills up and stalls its input.
    task automatic test_backpressure;
        write_atlas_size(15'd64);
        idle_on     = 1'b0;
        hold_cycles = 300;
        run_lists(30, 64);
        idle_on = 1'b1;
        drain();
    endtask

    task automatic test_random_settings;
        int unsigned side;
        write_atlas_size(15'd256);
        run_lists(20, 256);
        side = $urandom_range(1, 16384);
        write_atlas_size(15'(side));
        run_lists(20, side);
        write_atlas_size(15'd32);
        run_lists(15, 32);
    endtask

    // Last part: no idling on either side.
    task automatic test_back_to_back;
        write_atlas_size(15'd128);
        idle_on = 1'b0;
        run_lists(20, 128);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_shapes();
        test_atlas_extremes();
        test_backpressure();
        test_random_settings();
        test_back_to_back();

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_shelf_rectangle_packer: clean");
        end else begin
            $display("tb_shelf_rectangle_packer: errors");
        end
        $finish;
    end

endmodule
